>>> rtl/core/pt2d_pkg.sv
// Shared types and constants of the 2-D point transform.
`timescale 1ns / 1ps

package pt2d_pkg;

   localparam int PARAM_W = 16;
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;

   localparam int REFL_X_AXIS_Y = 500;
   localparam int REFL_Y_AXIS_X = 600;
   localparam int REFL_ANTI_X   = 550;
   localparam int REFL_ANTI_Y   = 500;

   localparam logic signed [PARAM_W-1:0] PARAM_C_RESET = 16'sd16384;

   typedef enum logic [3:0] {
      MODE_TRANSLATE = 4'd0,
      MODE_ROTATE    = 4'd1,
      MODE_SCALE     = 4'd2,
      MODE_REFL_X    = 4'd3,
      MODE_REFL_Y    = 4'd4,
      MODE_REFL_DIAG = 4'd5,
      MODE_REFL_ANTI = 4'd6,
      MODE_REFL_LINE = 4'd7,
      MODE_SHEAR_X   = 4'd8,
      MODE_SHEAR_Y   = 4'd9,
      MODE_SHEAR_XY  = 4'd10
   } mode_type;

   typedef enum logic [2:0] {
      REG_MODE = 3'd0,
      REG_A    = 3'd1,
      REG_B    = 3'd2,
      REG_C    = 3'd3,
      REG_D    = 3'd4
   } reg_index_type;

endpackage

>>> rtl/core/point_transform_2d_core.sv
// Pipelined 2-D affine point transform core.
`timescale 1ns / 1ps

// Usage
//   req channel: one point per transfer, tdata = {py, px} (px in the low bits).
//   rsp channel: one transformed point per transfer, tdata = {qy, qx},
//   tuser = {degenerate, clipped}.
//   csr port: APB-style; mode, param_a, param_b, param_c, param_d at byte
//   addresses 0, 4, 8, 12 and 16. Write only while no point is in flight.
// The stages are the input register, offset, multiply, sum, one stage per
// quotient bit of the line-reflection divider, and the output register.
// The divider stages set the depth; a point enters in every cycle while
// rsp is taken.
// After a parameter write the squares are registered, then k1, k2 and n.
// Reset clears the valid bits of all stages and loads the register
// defaults (mode translate, param_c = 16384, others 0).
// When rsp_tready is low with a result held, the whole pipeline holds
// and req_tready drops; nothing is lost or repeated.

module point_transform_2d_core
   import pt2d_pkg::*;
#(
   parameter int COORD_WIDTH     = 16,
   parameter int TRIG_FRAC_BITS  = 14,
   parameter int SHEAR_FRAC_BITS = 8
)
(
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // px, py
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]     req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // qx, qy
   output logic [((2*COORD_WIDTH+7)/8)*8-1:0]     rsp_tdata,
   // clipped, degenerate
   output logic [1:0]                             rsp_tuser,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [CSR_AW-1:0]                      csr_paddr,
   input  logic [CSR_DW-1:0]                      csr_pwdata,
   output logic [CSR_DW-1:0]                      csr_prdata,
   output logic                                   csr_pready
);

   localparam int CW  = COORD_WIDTH;
   localparam int DW  = ((2*COORD_WIDTH+7)/8)*8;
   localparam int WW  = ((CW > PARAM_W) ? CW : PARAM_W) + 1;
   localparam int EW  = PARAM_W + 1;
   localparam int NW  = 2*EW;
   localparam int KW  = NW + 1;
   localparam int LW  = WW + KW;
   localparam int SW  = LW + 2;
   localparam int QW  = WW + 1;
   localparam int MW  = CW + PARAM_W;
   localparam int RW  = WW + PARAM_W + 2;
   localparam int TF  = TRIG_FRAC_BITS;
   localparam int SF  = SHEAR_FRAC_BITS;

   // configuration registers
   logic                       csr_wr;
   reg_index_type              csr_idx;
   logic [3:0]                 mode_ff;
   logic signed [PARAM_W-1:0]  a_ff, b_ff, c_ff, d_ff;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TRANSLATE;
         a_ff    <= '0;
         b_ff    <= '0;
         c_ff    <= PARAM_C_RESET;
         d_ff    <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_MODE: mode_ff <= csr_pwdata[3:0];
            REG_A:    a_ff    <= csr_pwdata[PARAM_W-1:0];
            REG_B:    b_ff    <= csr_pwdata[PARAM_W-1:0];
            REG_C:    c_ff    <= csr_pwdata[PARAM_W-1:0];
            REG_D:    d_ff    <= csr_pwdata[PARAM_W-1:0];
            default:  ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_MODE: csr_prdata = CSR_DW'(mode_ff);
         REG_A:    csr_prdata = CSR_DW'($unsigned(a_ff));
         REG_B:    csr_prdata = CSR_DW'($unsigned(b_ff));
         REG_C:    csr_prdata = CSR_DW'($unsigned(c_ff));
         REG_D:    csr_prdata = CSR_DW'($unsigned(d_ff));
         default:  csr_prdata = '0;
      endcase
   end

   // line terms derived from the parameters
   logic signed [EW-1:0] ex, ey;
   logic signed [NW-1:0] exx_ff, eyy_ff, exy_ff;
   logic signed [NW-1:0] exx_in, eyy_in, exy_in;
   logic signed [KW-1:0] k1_ff, k2_ff, k1_in, k2_in;
   logic [NW-1:0]        n_ff, n_in;

   assign ex     = EW'(c_ff) - EW'(a_ff);
   assign ey     = EW'(d_ff) - EW'(b_ff);
   assign exx_in = NW'(ex) * NW'(ex);
   assign eyy_in = NW'(ey) * NW'(ey);
   assign exy_in = NW'(ex) * NW'(ey);
   assign k1_in  = KW'(exx_ff) - KW'(eyy_ff);
   assign k2_in  = KW'(exy_ff) <<< 1;
   assign n_in   = $unsigned(exx_ff) + $unsigned(eyy_ff);

   always_ff @(posedge clock) begin
      exx_ff <= exx_in;
      eyy_ff <= eyy_in;
      exy_ff <= exy_in;
      k1_ff  <= k1_in;
      k2_ff  <= k2_in;
      n_ff   <= n_in;
   end

   // pipeline advance
   logic out_valid_ff;
   logic en;

   assign en         = ~out_valid_ff | rsp_tready;
   assign req_tready = en;

   // stage 1: input register
   logic                 s1_valid_ff;
   logic signed [CW-1:0] s1_px_ff, s1_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_px_ff <= req_tdata[CW-1:0];
         s1_py_ff <= req_tdata[2*CW-1:CW];
      end
   end

   // stage 2: offsets from the pivot or line start
   logic                 s2_valid_ff;
   logic signed [CW-1:0] s2_px_ff, s2_py_ff;
   logic signed [WW-1:0] s2_u_ff, s2_v_ff, s2_u_in, s2_v_in;

   assign s2_u_in = WW'(s1_px_ff) - WW'(a_ff);
   assign s2_v_in = WW'(s1_py_ff) - WW'(b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_px_ff <= s1_px_ff;
         s2_py_ff <= s1_py_ff;
         s2_u_ff  <= s2_u_in;
         s2_v_ff  <= s2_v_in;
      end
   end

   // stage 3: products
   localparam int PRW = WW + PARAM_W;

   logic                  s3_valid_ff;
   logic signed [CW-1:0]  s3_px_ff, s3_py_ff;
   logic signed [PRW-1:0] s3_uc_ff, s3_vd_ff, s3_ud_ff, s3_vc_ff;
   logic signed [PRW-1:0] s3_uc_in, s3_vd_in, s3_ud_in, s3_vc_in;
   logic signed [MW-1:0]  s3_sx_ff, s3_sy_ff, s3_hx_ff, s3_hy_ff;
   logic signed [MW-1:0]  s3_sx_in, s3_sy_in, s3_hx_in, s3_hy_in;
   logic signed [LW-1:0]  s3_l1_ff, s3_l2_ff, s3_l3_ff, s3_l4_ff;
   logic signed [LW-1:0]  s3_l1_in, s3_l2_in, s3_l3_in, s3_l4_in;

   assign s3_uc_in = PRW'(s2_u_ff) * PRW'(c_ff);
   assign s3_vd_in = PRW'(s2_v_ff) * PRW'(d_ff);
   assign s3_ud_in = PRW'(s2_u_ff) * PRW'(d_ff);
   assign s3_vc_in = PRW'(s2_v_ff) * PRW'(c_ff);
   assign s3_sx_in = MW'(s2_px_ff) * MW'(a_ff);
   assign s3_sy_in = MW'(s2_py_ff) * MW'(b_ff);
   assign s3_hx_in = MW'(s2_py_ff) * MW'(a_ff);
   assign s3_hy_in = MW'(s2_px_ff) * MW'(b_ff);
   assign s3_l1_in = LW'(s2_u_ff) * LW'(k1_ff);
   assign s3_l2_in = LW'(s2_v_ff) * LW'(k2_ff);
   assign s3_l3_in = LW'(s2_u_ff) * LW'(k2_ff);
   assign s3_l4_in = LW'(s2_v_ff) * LW'(k1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_px_ff <= s2_px_ff;
         s3_py_ff <= s2_py_ff;
         s3_uc_ff <= s3_uc_in;
         s3_vd_ff <= s3_vd_in;
         s3_ud_ff <= s3_ud_in;
         s3_vc_ff <= s3_vc_in;
         s3_sx_ff <= s3_sx_in;
         s3_sy_ff <= s3_sy_in;
         s3_hx_ff <= s3_hx_in;
         s3_hy_ff <= s3_hy_in;
         s3_l1_ff <= s3_l1_in;
         s3_l2_ff <= s3_l2_in;
         s3_l3_ff <= s3_l3_in;
         s3_l4_ff <= s3_l4_in;
      end
   end

   // stage 4: mode results, line numerators to sign and magnitude
   logic signed [RW-1:0] px_w, py_w, rot_x, rot_y, shr_x, shr_y;
   logic signed [RW-1:0] alt_x_in, alt_y_in;
   logic signed [SW-1:0] num_x, num_y, n_half;
   logic [SW-1:0]        mag_x, mag_y;

   assign px_w   = RW'(s3_px_ff);
   assign py_w   = RW'(s3_py_ff);
   assign rot_x  = RW'(s3_uc_ff) - RW'(s3_vd_ff) + (RW'(1) <<< (TF-1));
   assign rot_y  = RW'(s3_ud_ff) + RW'(s3_vc_ff) + (RW'(1) <<< (TF-1));
   assign shr_x  = RW'(s3_hx_ff) + (RW'(1) <<< (SF-1));
   assign shr_y  = RW'(s3_hy_ff) + (RW'(1) <<< (SF-1));
   assign n_half = SW'($signed({1'b0, n_ff[NW-1:1]}));
   assign num_x  = SW'(s3_l1_ff) + SW'(s3_l2_ff) + n_half;
   assign num_y  = SW'(s3_l3_ff) - SW'(s3_l4_ff) + n_half;
   assign mag_x  = num_x[SW-1] ? $unsigned(-num_x) : $unsigned(num_x);
   assign mag_y  = num_y[SW-1] ? $unsigned(-num_y) : $unsigned(num_y);

   always_comb begin
      alt_x_in = px_w;
      alt_y_in = py_w;
      case (mode_ff)
         MODE_TRANSLATE: begin
            alt_x_in = px_w + RW'(a_ff);
            alt_y_in = py_w + RW'(b_ff);
         end
         MODE_ROTATE: begin
            alt_x_in = RW'(a_ff) + (rot_x >>> TF);
            alt_y_in = RW'(b_ff) + (rot_y >>> TF);
         end
         MODE_SCALE: begin
            alt_x_in = RW'(s3_sx_ff);
            alt_y_in = RW'(s3_sy_ff);
         end
         MODE_REFL_X: begin
            alt_y_in = RW'(REFL_X_AXIS_Y) - py_w;
         end
         MODE_REFL_Y: begin
            alt_x_in = RW'(REFL_Y_AXIS_X) - px_w;
         end
         MODE_REFL_DIAG: begin
            alt_x_in = py_w;
            alt_y_in = px_w;
         end
         MODE_REFL_ANTI: begin
            alt_x_in = RW'(REFL_ANTI_X) - py_w;
            alt_y_in = RW'(REFL_ANTI_Y) - px_w;
         end
         MODE_SHEAR_X: begin
            alt_x_in = px_w + (shr_x >>> SF);
         end
         MODE_SHEAR_Y: begin
            alt_y_in = py_w + (shr_y >>> SF);
         end
         MODE_SHEAR_XY: begin
            alt_x_in = px_w + (shr_x >>> SF);
            alt_y_in = py_w + (shr_y >>> SF);
         end
         default: ;
      endcase
   end

   // divider stages: one quotient bit per stage for each coordinate
   logic                 dv_valid_ff [0:QW];
   logic                 dv_neg_x_ff [0:QW];
   logic                 dv_neg_y_ff [0:QW];
   logic signed [RW-1:0] dv_alt_x_ff [0:QW];
   logic signed [RW-1:0] dv_alt_y_ff [0:QW];
   logic [NW-1:0]        dv_r_x_ff   [0:QW];
   logic [NW-1:0]        dv_r_y_ff   [0:QW];
   logic [QW-1:0]        dv_q_x_ff   [0:QW];
   logic [QW-1:0]        dv_q_y_ff   [0:QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (en) begin
         dv_valid_ff[0] <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_neg_x_ff[0] <= num_x[SW-1];
         dv_neg_y_ff[0] <= num_y[SW-1];
         dv_alt_x_ff[0] <= alt_x_in;
         dv_alt_y_ff[0] <= alt_y_in;
         dv_r_x_ff[0]   <= mag_x[QW+NW-1:QW];
         dv_r_y_ff[0]   <= mag_y[QW+NW-1:QW];
         dv_q_x_ff[0]   <= mag_x[QW-1:0];
         dv_q_y_ff[0]   <= mag_y[QW-1:0];
      end
   end

   for (genvar i = 0; i < QW; i++) begin : g_div
      logic [NW:0]   t_x, t_y;
      logic          ge_x, ge_y;
      logic [NW-1:0] r_x_in, r_y_in;
      logic [QW-1:0] q_x_in, q_y_in;

      assign t_x    = {dv_r_x_ff[i], dv_q_x_ff[i][QW-1]};
      assign t_y    = {dv_r_y_ff[i], dv_q_y_ff[i][QW-1]};
      assign ge_x   = t_x >= {1'b0, n_ff};
      assign ge_y   = t_y >= {1'b0, n_ff};
      assign r_x_in = ge_x ? NW'(t_x - {1'b0, n_ff}) : t_x[NW-1:0];
      assign r_y_in = ge_y ? NW'(t_y - {1'b0, n_ff}) : t_y[NW-1:0];
      assign q_x_in = {dv_q_x_ff[i][QW-2:0], ge_x};
      assign q_y_in = {dv_q_y_ff[i][QW-2:0], ge_y};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[i+1] <= 1'b0;
         end else if (en) begin
            dv_valid_ff[i+1] <= dv_valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_neg_x_ff[i+1] <= dv_neg_x_ff[i];
            dv_neg_y_ff[i+1] <= dv_neg_y_ff[i];
            dv_alt_x_ff[i+1] <= dv_alt_x_ff[i];
            dv_alt_y_ff[i+1] <= dv_alt_y_ff[i];
            dv_r_x_ff[i+1]   <= r_x_in;
            dv_r_y_ff[i+1]   <= r_y_in;
            dv_q_x_ff[i+1]   <= q_x_in;
            dv_q_y_ff[i+1]   <= q_y_in;
         end
      end
   end

   // output stage: floor correction, selection, saturation
   function automatic logic [CW:0] sat_fn(input logic signed [RW-1:0] v);
      logic ovf;
      ovf = ~(&v[RW-1:CW-1] | ~|v[RW-1:CW-1]);
      if (ovf) begin
         sat_fn = {1'b1, v[RW-1], {(CW-1){~v[RW-1]}}};
      end else begin
         sat_fn = {1'b0, v[CW-1:0]};
      end
   endfunction

   logic signed [QW:0]   qm_x, qm_y, ql_x, ql_y;
   logic signed [RW-1:0] sel_x, sel_y;
   logic                 line_sel, degen_in, clip_in;
   logic [CW:0]          sat_x, sat_y;
   logic signed [CW-1:0] qx_ff, qy_ff;
   logic                 clip_ff, degen_ff;

   assign qm_x = $signed({1'b0, dv_q_x_ff[QW]});
   assign qm_y = $signed({1'b0, dv_q_y_ff[QW]});
   assign ql_x = dv_neg_x_ff[QW] ?
                 -qm_x - $signed({{QW{1'b0}}, |dv_r_x_ff[QW]}) : qm_x;
   assign ql_y = dv_neg_y_ff[QW] ?
                 -qm_y - $signed({{QW{1'b0}}, |dv_r_y_ff[QW]}) : qm_y;

   assign line_sel = (mode_ff == MODE_REFL_LINE) && (n_ff != '0);
   assign degen_in = (mode_ff == MODE_REFL_LINE) && (n_ff == '0);
   assign sel_x    = line_sel ? RW'(a_ff) + RW'(ql_x) : dv_alt_x_ff[QW];
   assign sel_y    = line_sel ? RW'(b_ff) + RW'(ql_y) : dv_alt_y_ff[QW];
   assign sat_x    = sat_fn(sel_x);
   assign sat_y    = sat_fn(sel_y);
   assign clip_in  = sat_x[CW] | sat_y[CW];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= dv_valid_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qx_ff    <= sat_x[CW-1:0];
         qy_ff    <= sat_y[CW-1:0];
         clip_ff  <= clip_in;
         degen_ff <= degen_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = DW'({qy_ff, qx_ff});
   assign rsp_tuser  = {degen_ff, clip_ff};

endmodule

>>> rtl/core/pt2d_checker.sv
// Port-level checks of the 2-D point transform core, bound to the top level.
`timescale 1ns / 1ps

module pt2d_checker #(
   parameter int COORD_WIDTH = 16
)
(
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_tready,
   input logic                                   rsp_tvalid,
   input logic                                   rsp_tready,
   input logic [((2*COORD_WIDTH+7)/8)*8-1:0]     rsp_tdata,
   input logic [1:0]                             rsp_tuser,
   input logic                                   csr_pready
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
      else $error("stalled transfer changed");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input held while output empty");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("degenerate result flagged as clipped");

   a_pready: assert property (@(posedge clock)
      csr_pready)
      else $error("csr wait state");

endmodule

bind point_transform_2d_core pt2d_checker #(.COORD_WIDTH(COORD_WIDTH)) u_pt2d_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_pready (csr_pready)
);

>>> sim/point_transform_2d_checker.sv
// Checker for the 2-D point transform: predicts each transfer and compares results.
`timescale 1ns / 1ps

module point_transform_2d_checker
   import pt2d_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [31:0]         req_tdata,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [31:0]         rsp_tdata,
   input  logic [1:0]          rsp_tuser,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   input  logic                csr_pready,
   output int                  failures,
   output int                  pending
);

   typedef struct packed {
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic               clipped;
      logic               degenerate;
   } point_result_t;

   logic [3:0] cfg_mode;
   longint     cfg_a, cfg_b, cfg_c, cfg_d;
   point_result_t expected_points[$];

   function automatic longint floor_div(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      return q;
   endfunction

   function automatic logic signed [15:0] clamp(longint v, inout logic clip);
      if (v > 32767) begin
         clip = 1'b1;
         return 16'sd32767;
      end
      if (v < -32768) begin
         clip = 1'b1;
         return -16'sd32768;
      end
      return v[15:0];
   endfunction

   function automatic point_result_t transform_point(longint px, longint py);
      point_result_t r;
      longint x, y, u, v, ex, ey, n, k1, k2;
      logic clip;
      x = px;
      y = py;
      clip = 1'b0;
      r.degenerate = 1'b0;
      case (cfg_mode)
         MODE_TRANSLATE: begin
            x = px + cfg_a;
            y = py + cfg_b;
         end
         MODE_ROTATE: begin
            u = px - cfg_a;
            v = py - cfg_b;
            x = cfg_a + ((u * cfg_c - v * cfg_d + 64'sd8192) >>> 14);
            y = cfg_b + ((u * cfg_d + v * cfg_c + 64'sd8192) >>> 14);
         end
         MODE_SCALE: begin
            x = px * cfg_a;
            y = py * cfg_b;
         end
         MODE_REFL_X: y = REFL_X_AXIS_Y - py;
         MODE_REFL_Y: x = REFL_Y_AXIS_X - px;
         MODE_REFL_DIAG: begin
            x = py;
            y = px;
         end
         MODE_REFL_ANTI: begin
            x = REFL_ANTI_X - py;
            y = REFL_ANTI_Y - px;
         end
         MODE_REFL_LINE: begin
            ex = cfg_c - cfg_a;
            ey = cfg_d - cfg_b;
            n = ex * ex + ey * ey;
            if (n == 0) begin
               r.degenerate = 1'b1;
            end else begin
               u = px - cfg_a;
               v = py - cfg_b;
               k1 = ex * ex - ey * ey;
               k2 = 2 * ex * ey;
               x = cfg_a + floor_div(u * k1 + v * k2 + n / 2, n);
               y = cfg_b + floor_div(u * k2 - v * k1 + n / 2, n);
            end
         end
         MODE_SHEAR_X: x = px + ((cfg_a * py + 64'sd128) >>> 8);
         MODE_SHEAR_Y: y = py + ((cfg_b * px + 64'sd128) >>> 8);
         MODE_SHEAR_XY: begin
            x = px + ((cfg_a * py + 64'sd128) >>> 8);
            y = py + ((cfg_b * px + 64'sd128) >>> 8);
         end
         default: ;
      endcase
      r.qx = clamp(x, clip);
      r.qy = clamp(y, clip);
      r.clipped = clip;
      return r;
   endfunction

   assign pending = expected_points.size();

   always @(posedge clock) begin
      point_result_t want, got;
      if (reset) begin
         cfg_mode <= MODE_TRANSLATE;
         cfg_a <= 0;
         cfg_b <= 0;
         cfg_c <= PARAM_C_RESET;
         cfg_d <= 0;
         expected_points.delete();
         failures <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr >> 2)
               REG_MODE: cfg_mode <= csr_pwdata[3:0];
               REG_A:    cfg_a <= $signed(csr_pwdata[15:0]);
               REG_B:    cfg_b <= $signed(csr_pwdata[15:0]);
               REG_C:    cfg_c <= $signed(csr_pwdata[15:0]);
               REG_D:    cfg_d <= $signed(csr_pwdata[15:0]);
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.qx = rsp_tdata[15:0];
            got.qy = rsp_tdata[31:16];
            got.clipped = rsp_tuser[0];
            got.degenerate = rsp_tuser[1];
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected transfer, actual %p", $time, got);
               failures <= failures + 1;
            end else begin
               want = expected_points.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                  failures <= failures + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_points.push_back(transform_point($signed(req_tdata[15:0]),
                                                      $signed(req_tdata[31:16])));
      end
   end

endmodule

>>> sim/testbench.sv
// Top of the 2-D point transform testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
   import pt2d_pkg::*;

   localparam int IDLE_LIMIT = 5000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata = '0;   // px, py
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;        // qx, qy
   logic [1:0]        rsp_tuser;        // clipped, degenerate
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;
   int                failures;
   int                pending;
   logic              calm = 1'b0;
   int                stall_left = 0;
   int                idle_cycles = 0;

   always #10 clock = ~clock;

   point_transform_2d_core u_dut (.*);

   point_transform_2d_checker u_checker (.*);

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 11);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   task automatic write_reg(reg_index_type idx, logic [15:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_AW'(idx) << 2;
      csr_pwdata <= {16'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // hold the sender until every transfer has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_config(logic [3:0] mode, logic [15:0] a, logic [15:0] b,
                             logic [15:0] c, logic [15:0] d);
      drain();
      repeat (30) @(posedge clock);
      write_reg(REG_MODE, {12'h0, mode});
      write_reg(REG_A, a);
      write_reg(REG_B, b);
      write_reg(REG_C, c);
      write_reg(REG_D, d);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_point(logic [15:0] px, logic [15:0] py);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_value();
      logic [15:0] corners[5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
      case ($urandom_range(0, 4))
         0: return corners[$urandom_range(0, 4)];
         1: return 16'($signed($urandom_range(0, 1200)) - 600);
         2: return 16'($signed($urandom_range(0, 1024)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [3:0]  mode;
      logic [15:0] a, b, c, d;
      logic [3:0]  dir_modes[13] = '{MODE_TRANSLATE, MODE_ROTATE, MODE_SCALE, MODE_REFL_X,
                                     MODE_REFL_Y, MODE_REFL_DIAG, MODE_REFL_ANTI,
                                     MODE_REFL_LINE, MODE_SHEAR_X, MODE_SHEAR_Y,
                                     MODE_SHEAR_XY, MODE_REFL_LINE, 4'd15};
      logic [15:0] dir_a[13] = '{16'h7FFF, 16'd100, 16'hFFFD, 0, 0, 0, 0, 0, 16'd384,
                                 0, 16'h7FFF, 16'd5, 0};
      logic [15:0] dir_b[13] = '{16'h8000, 16'hFFCE, 16'h7FFF, 0, 0, 0, 0, 0, 0,
                                 16'hFF80, 16'h8000, 16'd5, 0};
      logic [15:0] dir_c[13] = '{0, 16'd11585, 0, 0, 0, 0, 0, 16'd100, 0, 0, 0, 16'd5, 0};
      logic [15:0] dir_d[13] = '{0, 16'd11585, 0, 0, 0, 0, 0, 16'd37, 0, 0, 0, 16'd5, 0};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 13; i++) begin
         set_config(dir_modes[i], dir_a[i], dir_b[i], dir_c[i], dir_d[i]);
         send_point(16'h7FFF, 16'h8000);
         send_point(16'h8000, 16'h7FFF);
      end

      for (int ph = 0; ph < 27; ph++) begin
         if (ph >= 24) calm = 1'b1;
         mode = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(0, 10));
         a = pick_value();
         b = pick_value();
         c = pick_value();
         d = pick_value();
         if (mode == MODE_REFL_LINE && $urandom_range(0, 5) == 0) begin
            c = a;
            d = b;
         end
         set_config(mode, a, b, c, d);
         for (int k = 0; k < 50; k++) begin
            if (ph == 5 && k == 25) drain();
            send_point(pick_value(), pick_value());
         end
      end

      drain();
      repeat (30) @(posedge clock);
      if (failures == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
